### src/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg: shared types, constants and fixed-point helpers
// Signed fixed-point value type, saturating multiply/add, register indexes,
// datapath operation codes and controller states.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int VW  = 32;           // value width
  localparam int FB  = 16;           // fraction bits
  localparam int CW  = 31;           // width of the unsigned Q15.16 setup registers
  localparam int TSW = 17;           // width of the time step register
  localparam int QW  = VW - 1 + FB;  // width of a divider quotient

  typedef logic signed [VW-1:0] val_t;

  localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};

  // profile segment codes
  localparam logic [1:0] SEG_ACCEL  = 2'd0;
  localparam logic [1:0] SEG_CRUISE = 2'd1;
  localparam logic [1:0] SEG_DECEL  = 2'd2;
  localparam logic [1:0] SEG_DONE   = 2'd3;

  typedef enum logic [2:0] {
    CFG_ACCEL  = 3'd0,
    CFG_VEL    = 3'd1,
    CFG_POS    = 3'd2,
    CFG_TSTEP  = 3'd3,
    CFG_PSCALE = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DIV_LOAD_A,
    OP_DIV_STEP,
    OP_EOA_LOAD_C,
    OP_STORE_EOC,
    OP_R0, OP_R1, OP_R2, OP_R3, OP_R4,
    OP_T0, OP_T1, OP_T2, OP_T3, OP_T4, OP_T5,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DIV_A,
    CS_EOA,
    CS_DIV_C,
    CS_RECALC,
    CS_TICK,
    CS_EMIT
  } ctl_state_t;

  // (a*b) >> FB, truncated toward zero, saturated
  function automatic val_t qmul(val_t a, val_t b);
    logic              neg;
    logic [VW-1:0]     ma;
    logic [VW-1:0]     mb;
    logic [2*VW-1:0]   p;
    logic [2*VW-FB-1:0] q;
    logic [VW-1:0]     lim;
    logic [VW-1:0]     mag;
    neg = a[VW-1] ^ b[VW-1];
    ma  = a[VW-1] ? VW'(-a) : VW'(a);
    mb  = b[VW-1] ? VW'(-b) : VW'(b);
    p   = (2*VW)'(ma) * (2*VW)'(mb);
    q   = p[2*VW-1:FB];
    lim = neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    mag = (q > (2*VW-FB)'(lim)) ? lim : q[VW-1:0];
    return neg ? val_t'(-mag) : val_t'(mag);
  endfunction

  // saturating add
  function automatic val_t sadd(val_t a, val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
    return s[VW-1:0];
  endfunction

endpackage

### src/tmp_div.sv
// ----------------------------------------------------------------------------
// tmp_div: restoring divider, one quotient bit per cycle
// Computes (num << FB) / den for unsigned setup values, saturated; a zero
// divisor gives the largest value.
// ----------------------------------------------------------------------------
module tmp_div (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    step,
  input  logic [tmp_pkg::CW-1:0]  num,
  input  logic [tmp_pkg::CW-1:0]  den,
  output tmp_pkg::val_t           quo
);

  logic [tmp_pkg::QW-1:0] nq_r, nq_nxt;
  logic [tmp_pkg::CW-1:0] rem_r, rem_nxt;
  logic [tmp_pkg::CW-1:0] den_r, den_nxt;
  logic [tmp_pkg::CW:0]   rem_sh;
  logic                   ge;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_r, nq_r[tmp_pkg::QW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    nq_nxt  = nq_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    if (load) begin
      nq_nxt  = {num, {tmp_pkg::FB{1'b0}}};
      rem_nxt = '0;
      den_nxt = den;
    end else if (step) begin
      nq_nxt  = {nq_r[tmp_pkg::QW-2:0], ge};
      rem_nxt = ge ? tmp_pkg::CW'(rem_sh - {1'b0, den_r}) : tmp_pkg::CW'(rem_sh);
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // saturate quotient
  always_comb begin
    if (den_r == '0 || nq_r[tmp_pkg::QW-1:tmp_pkg::VW-1] != '0) quo = tmp_pkg::VMAX;
    else quo = tmp_pkg::val_t'(nq_r[tmp_pkg::VW-1:0]);
  end

endmodule

### src/tmp_dp.sv
// ----------------------------------------------------------------------------
// tmp_dp: profile datapath
// Setup registers, profile coefficients, elapsed time, one shared fixed-point
// multiplier, the divider and the result register.
// ----------------------------------------------------------------------------
module tmp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tmp_pkg::dp_op_t     op,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_busy,
  output logic                out_valid,
  output tmp_pkg::val_t       out_pos,
  output tmp_pkg::val_t       out_vel,
  output logic [1:0]          out_seg,
  output logic                out_done
);

  typedef tmp_pkg::val_t val_t;

  logic [tmp_pkg::CW-1:0]  accel_r, vel_r, posmax_r, pscale_r;
  logic [tmp_pkg::TSW-1:0] tstep_r;

  val_t elapsed_r, half_r, coff_r, dsq_r, dlin_r, dconst_r;
  val_t eoa_r, eoc_r, eom_r;
  val_t mul_r, acc_r, ppos_r, pvel_r;
  logic [1:0] seg_r;
  logic       done_r;

  val_t out_pos_r, out_vel_r;
  logic [1:0] out_seg_r;
  logic       out_done_r, out_valid_r;

  val_t a_v, v_v, p_v, s_v, ts_v, t;
  val_t mul_a, mul_b, prod, quo;
  logic [1:0] seg_now;
  logic div_load, div_step;
  logic [tmp_pkg::CW-1:0] div_num, div_den;

  assign a_v  = val_t'({1'b0, accel_r});
  assign v_v  = val_t'({1'b0, vel_r});
  assign p_v  = val_t'({1'b0, posmax_r});
  assign s_v  = val_t'({1'b0, pscale_r});
  assign ts_v = val_t'({{(tmp_pkg::VW-tmp_pkg::TSW){1'b0}}, tstep_r});
  assign t    = elapsed_r;

  // setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r  <= tmp_pkg::CW'(65536);
      vel_r    <= tmp_pkg::CW'(65536);
      posmax_r <= tmp_pkg::CW'(65536);
      tstep_r  <= tmp_pkg::TSW'(655);
      pscale_r <= tmp_pkg::CW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        tmp_pkg::CFG_ACCEL:  accel_r  <= cfg_data[tmp_pkg::CW-1:0];
        tmp_pkg::CFG_VEL:    vel_r    <= cfg_data[tmp_pkg::CW-1:0];
        tmp_pkg::CFG_POS:    posmax_r <= cfg_data[tmp_pkg::CW-1:0];
        tmp_pkg::CFG_TSTEP:  tstep_r  <= cfg_data[tmp_pkg::TSW-1:0];
        tmp_pkg::CFG_PSCALE: pscale_r <= cfg_data[tmp_pkg::CW-1:0];
        default: ;
      endcase
    end
  end

  // divider operands
  assign div_load = (op == tmp_pkg::OP_DIV_LOAD_A) || (op == tmp_pkg::OP_EOA_LOAD_C);
  assign div_step = (op == tmp_pkg::OP_DIV_STEP);
  assign div_num  = (op == tmp_pkg::OP_EOA_LOAD_C) ? posmax_r : vel_r;
  assign div_den  = (op == tmp_pkg::OP_EOA_LOAD_C) ? vel_r : accel_r;

  tmp_div u_div (
    .clk  (clk),
    .load (div_load),
    .step (div_step),
    .num  (div_num),
    .den  (div_den),
    .quo  (quo)
  );

  // segment of the current time
  always_comb begin
    if (t <= eoa_r)      seg_now = tmp_pkg::SEG_ACCEL;
    else if (t <= eoc_r) seg_now = tmp_pkg::SEG_CRUISE;
    else if (t <= eom_r) seg_now = tmp_pkg::SEG_DECEL;
    else                 seg_now = tmp_pkg::SEG_DONE;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      tmp_pkg::OP_R0: begin mul_a = v_v;   mul_b = eoa_r; end
      tmp_pkg::OP_R1: begin mul_a = a_v;   mul_b = eoc_r; end
      tmp_pkg::OP_R2: begin mul_a = eoc_r; mul_b = eoc_r; end
      tmp_pkg::OP_R3: begin mul_a = half_r; mul_b = mul_r; end
      tmp_pkg::OP_T0: begin
        mul_b = t;
        case (seg_now)
          tmp_pkg::SEG_ACCEL:  mul_a = half_r;
          tmp_pkg::SEG_CRUISE: mul_a = v_v;
          tmp_pkg::SEG_DECEL:  mul_a = dsq_r;
          default:             mul_a = '0;
        endcase
      end
      tmp_pkg::OP_T1: begin mul_a = mul_r; mul_b = t; end
      tmp_pkg::OP_T2: begin
        mul_b = t;
        mul_a = (seg_r == tmp_pkg::SEG_ACCEL) ? val_t'(half_r <<< 1) : dlin_r;
      end
      tmp_pkg::OP_T3: begin mul_a = val_t'(dsq_r <<< 1); mul_b = t; end
      tmp_pkg::OP_T5: begin mul_a = ppos_r; mul_b = s_v; end
      default: ;
    endcase
  end

  assign prod = tmp_pkg::qmul(mul_a, mul_b);

  // coefficient and tick sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      half_r    <= '0;
      coff_r    <= '0;
      dsq_r     <= '0;
      dlin_r    <= '0;
      dconst_r  <= '0;
      eoa_r     <= '0;
      eoc_r     <= '0;
      eom_r     <= '0;
    end else begin
      case (op)
        tmp_pkg::OP_EOA_LOAD_C: eoa_r <= quo;
        tmp_pkg::OP_STORE_EOC:  eoc_r <= quo;
        tmp_pkg::OP_R0: begin
          eom_r  <= tmp_pkg::sadd(eoa_r, eoc_r);
          half_r <= a_v >>> 1;
          dsq_r  <= -(a_v >>> 1);
        end
        tmp_pkg::OP_R1: coff_r   <= -(mul_r >>> 1);
        tmp_pkg::OP_R2: dlin_r   <= tmp_pkg::sadd(mul_r, v_v);
        tmp_pkg::OP_R4: begin
          dconst_r  <= tmp_pkg::sadd(-mul_r, coff_r);
          elapsed_r <= '0;
        end
        tmp_pkg::OP_T0: if (seg_now == tmp_pkg::SEG_DONE) elapsed_r <= '0;
        tmp_pkg::OP_T5: elapsed_r <= tmp_pkg::sadd(elapsed_r, ts_v);
        default: ;
      endcase
    end
  end

  // working values of one tick
  always_ff @(posedge clk) begin
    case (op)
      tmp_pkg::OP_R0, tmp_pkg::OP_R1, tmp_pkg::OP_R2, tmp_pkg::OP_R3,
      tmp_pkg::OP_T5: mul_r <= prod;
      tmp_pkg::OP_T0: begin
        mul_r  <= prod;
        seg_r  <= seg_now;
        done_r <= (seg_now == tmp_pkg::SEG_DONE);
        ppos_r <= '0;
        pvel_r <= '0;
      end
      tmp_pkg::OP_T1: begin
        mul_r <= prod;
        if (seg_r == tmp_pkg::SEG_CRUISE) begin
          ppos_r <= tmp_pkg::sadd(mul_r, coff_r);
          pvel_r <= v_v;
        end
      end
      tmp_pkg::OP_T2: begin
        mul_r <= prod;
        if (seg_r == tmp_pkg::SEG_ACCEL) ppos_r <= mul_r;
        acc_r <= mul_r;
      end
      tmp_pkg::OP_T3: begin
        mul_r <= prod;
        if (seg_r == tmp_pkg::SEG_ACCEL) pvel_r <= mul_r;
        acc_r <= tmp_pkg::sadd(acc_r, mul_r);
      end
      tmp_pkg::OP_T4: begin
        if (seg_r == tmp_pkg::SEG_DECEL) begin
          ppos_r <= tmp_pkg::sadd(acc_r, dconst_r);
          pvel_r <= tmp_pkg::sadd(mul_r, dlin_r);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == tmp_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == tmp_pkg::OP_EMIT) begin
      out_pos_r  <= mul_r;
      out_vel_r  <= pvel_r;
      out_seg_r  <= seg_r;
      out_done_r <= done_r;
    end
  end

  assign out_busy  = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign out_vel   = out_vel_r;
  assign out_seg   = out_seg_r;
  assign out_done  = out_done_r;

endmodule

### src/tmp_ctrl.sv
// ----------------------------------------------------------------------------
// tmp_ctrl: sequencing controller
// Accepts a tick, runs the two divisions and the coefficient steps on a
// restart, then the evaluation steps, and hands the result to the output.
// ----------------------------------------------------------------------------
module tmp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_restart,
  input  logic             out_busy,
  output logic             in_ready,
  output tmp_pkg::dp_op_t  op
);

  localparam int CNTW = $clog2(tmp_pkg::QW);

  tmp_pkg::ctl_state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmp_pkg::CS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    op        = tmp_pkg::OP_NONE;
    case (state_r)
      tmp_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          if (in_restart) begin
            op        = tmp_pkg::OP_DIV_LOAD_A;
            state_nxt = tmp_pkg::CS_DIV_A;
          end else begin
            state_nxt = tmp_pkg::CS_TICK;
          end
        end
      end
      tmp_pkg::CS_DIV_A, tmp_pkg::CS_DIV_C: begin
        op = tmp_pkg::OP_DIV_STEP;
        if (cnt_r == CNTW'(tmp_pkg::QW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == tmp_pkg::CS_DIV_A) ? tmp_pkg::CS_EOA : tmp_pkg::CS_RECALC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tmp_pkg::CS_EOA: begin
        op        = tmp_pkg::OP_EOA_LOAD_C;
        state_nxt = tmp_pkg::CS_DIV_C;
      end
      tmp_pkg::CS_RECALC: begin
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r[2:0])
          3'd0: op = tmp_pkg::OP_STORE_EOC;
          3'd1: op = tmp_pkg::OP_R0;
          3'd2: op = tmp_pkg::OP_R1;
          3'd3: op = tmp_pkg::OP_R2;
          3'd4: op = tmp_pkg::OP_R3;
          default: begin
            op        = tmp_pkg::OP_R4;
            cnt_nxt   = '0;
            state_nxt = tmp_pkg::CS_TICK;
          end
        endcase
      end
      tmp_pkg::CS_TICK: begin
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r[2:0])
          3'd0: op = tmp_pkg::OP_T0;
          3'd1: op = tmp_pkg::OP_T1;
          3'd2: op = tmp_pkg::OP_T2;
          3'd3: op = tmp_pkg::OP_T3;
          3'd4: op = tmp_pkg::OP_T4;
          default: begin
            op        = tmp_pkg::OP_T5;
            cnt_nxt   = '0;
            state_nxt = tmp_pkg::CS_EMIT;
          end
        endcase
      end
      tmp_pkg::CS_EMIT: begin
        if (!out_busy) begin
          op        = tmp_pkg::OP_EMIT;
          state_nxt = tmp_pkg::CS_IDLE;
        end
      end
      default: state_nxt = tmp_pkg::CS_IDLE;
    endcase
  end

endmodule

### src/trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_motion_profile: trapezoidal move reference generator
// Gives scaled reference position and velocity of an accelerate / cruise /
// decelerate move, one result beat per tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the in_ channel is one servo tick; in_tdata[0] set means
//   restart: the coefficients are rebuilt from the setup registers and time
//   starts at zero. Each tick yields exactly one beat on the out_ channel.
//   Setup registers are written through cfg_ (index, data) while idle, a rule
//   for the user that the block does not enforce; cfg_ready is always high.
// Sequence:
//   After acceptance a plain tick runs 6 evaluation steps through the single
//   shared multiplier, then the output load. A restart first adds two passes
//   of the bit-serial divider, one divider reload and 6 coefficient steps.
//   One tick is in work at a time; the next tick is accepted while the
//   previous result still waits in the output register.
// Reset and stall:
//   Synchronous reset clears time and coefficients and loads default setup.
//   When the receiver stalls, the result holds and the sequencer waits at the
//   output load step.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [31:0] ref_position, [63:32] ref_velocity
  output logic [2:0]  out_tuser,   // [1:0] segment, [2] move_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  tmp_pkg::dp_op_t op;
  tmp_pkg::val_t   pos, vel;
  logic            out_busy;
  logic [1:0]      seg;
  logic            done;

  assign cfg_ready = 1'b1;

  tmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .out_busy   (out_busy),
    .in_ready   (in_tready),
    .op         (op)
  );

  tmp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_tready),
    .out_busy  (out_busy),
    .out_valid (out_tvalid),
    .out_pos   (pos),
    .out_vel   (vel),
    .out_seg   (seg),
    .out_done  (done)
  );

  assign out_tdata = {vel, pos};
  assign out_tuser = {done, seg};

endmodule

### src/tmp_check.sv
// ----------------------------------------------------------------------------
// tmp_check: port-level checks for the motion profile block
// Watches the result channel and reset behavior.
// ----------------------------------------------------------------------------
module tmp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // finishing beat carries zero outputs and the finished segment
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == tmp_pkg::SEG_DONE && out_tdata == 64'd0)
    else $error("done beat malformed");

  // finished segment only with done flag
  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == tmp_pkg::SEG_DONE |-> out_tuser[2])
    else $error("finished segment without done");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind trapezoid_motion_profile tmp_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: trapezoid_motion_profile testbench
// Ticks and restarts are driven from a queue and predicted by an in-bench
// fixed-point model of the move profile. Every result beat is compared field
// by field against the oldest prediction. Setup registers are rewritten
// between phases while the block is idle, and the idle patterns of both sides
// change for each of three runs of random moves.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int     STALL_LIMIT = 20000;
  localparam int     LONG_HOLD = 400;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [1:0]  segment;
    logic        done;
  } profile_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  trapezoid_motion_profile u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // profile model state
  logic [30:0] m_accel, m_vel, m_pos, m_scale;
  logic [16:0] m_tstep;
  longint      m_time, m_half_acc, m_cruise_off, m_dec_sq, m_dec_lin, m_dec_const;
  longint      m_end_acc, m_end_cruise, m_end_move;

  logic [7:0]    tick_queue[$];
  profile_beat_t expected_beats[$];
  bit            failed;
  logic          in_taken;
  int            send_idle_pct, recv_idle_pct;
  int            hold_reqs, hold_seen, hold_cnt;
  int            quiet_cycles;

  function automatic longint clamp32(longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  // truncating Q16.16 multiply with saturation
  function automatic longint fx_mul(longint a, longint b);
    logic        neg;
    logic [63:0] ua, ub, prod, lim;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = (ua * ub) >> 16;
    lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (prod > lim) prod = lim;
    return neg ? -longint'(prod) : longint'(prod);
  endfunction

  // quotient of two register values, divide by zero gives the max
  function automatic longint fx_div(longint n, longint d);
    if (d <= 0) return Q_MAX;
    return clamp32((n << 16) / d);
  endfunction

  task automatic rebuild_profile();
    longint a, v, p;
    a = m_accel; v = m_vel; p = m_pos;
    m_end_acc    = fx_div(v, a);
    m_end_cruise = fx_div(p, v);
    m_end_move   = clamp32(m_end_acc + m_end_cruise);
    m_half_acc   = a >>> 1;
    m_cruise_off = -(fx_mul(v, m_end_acc) >>> 1);
    m_dec_sq     = -m_half_acc;
    m_dec_lin    = clamp32(fx_mul(a, m_end_cruise) + v);
    m_dec_const  = clamp32(-fx_mul(m_half_acc, fx_mul(m_end_cruise, m_end_cruise))
                           + m_cruise_off);
    m_time = 0;
  endtask

  task automatic predict_tick(input logic restart, output profile_beat_t r);
    longint t, pos, vel;
    pos = 0; vel = 0;
    r.done = 1'b0;
    if (restart) rebuild_profile();
    t = m_time;
    if (t <= m_end_acc) begin
      r.segment = tmp_pkg::SEG_ACCEL;
      pos = fx_mul(fx_mul(m_half_acc, t), t);
      vel = fx_mul(clamp32(2 * m_half_acc), t);
    end else if (t <= m_end_cruise) begin
      r.segment = tmp_pkg::SEG_CRUISE;
      pos = clamp32(fx_mul(longint'(m_vel), t) + m_cruise_off);
      vel = m_vel;
    end else if (t <= m_end_move) begin
      r.segment = tmp_pkg::SEG_DECEL;
      pos = clamp32(clamp32(fx_mul(fx_mul(m_dec_sq, t), t) + fx_mul(m_dec_lin, t))
                    + m_dec_const);
      vel = clamp32(fx_mul(clamp32(2 * m_dec_sq), t) + m_dec_lin);
    end else begin
      r.segment = tmp_pkg::SEG_DONE;
      r.done = 1'b1;
      m_time = 0;
    end
    m_time = clamp32(m_time + longint'(m_tstep));
    r.position = 32'(fx_mul(pos, longint'(m_scale)));
    r.velocity = 32'(vel);
  endtask

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // tick driver: next beat once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= tick_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and long hold-offs
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_seen + 1;
      hold_cnt  = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on accepted ticks, check accepted results
  always @(posedge clk) begin
    profile_beat_t want, got;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (tmp_pkg::cfg_idx_t'(cfg_index))
          tmp_pkg::CFG_ACCEL:  m_accel = cfg_data[30:0];
          tmp_pkg::CFG_VEL:    m_vel   = cfg_data[30:0];
          tmp_pkg::CFG_POS:    m_pos   = cfg_data[30:0];
          tmp_pkg::CFG_TSTEP:  m_tstep = cfg_data[16:0];
          tmp_pkg::CFG_PSCALE: m_scale = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_tick(in_tdata[0], want);
        expected_beats.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[63:32], out_tuser[1:0], out_tuser[2]};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          failed = 1'b1;
        end else begin
          want = expected_beats.pop_front();
          if (got.position !== want.position) begin
            $display("%0t: position exp %h got %h", $time, want.position, got.position);
            failed = 1'b1;
          end
          if (got.velocity !== want.velocity) begin
            $display("%0t: velocity exp %h got %h", $time, want.velocity, got.velocity);
            failed = 1'b1;
          end
          if (got.segment !== want.segment) begin
            $display("%0t: segment exp %0d got %0d", $time, want.segment, got.segment);
            failed = 1'b1;
          end
          if (got.done !== want.done) begin
            $display("%0t: move_done exp %0d got %0d", $time, want.done, got.done);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input tmp_pkg::cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (tick_queue.size() == 0 && expected_beats.size() == 0 && !in_tvalid);
    repeat (12) @(posedge clk);
  endtask

  task automatic add_ticks(input int count, input int restart_odds);
    for (int i = 0; i < count; i++)
      tick_queue.push_back({7'd0, (i == 0) || ($urandom_range(restart_odds - 1) == 0)});
  endtask

  // a move setup: mostly short moves, sometimes raw 32-bit values
  task automatic random_setup();
    if ($urandom_range(5) == 0) begin
      write_reg(tmp_pkg::CFG_ACCEL, $urandom());
      write_reg(tmp_pkg::CFG_VEL, $urandom());
      write_reg(tmp_pkg::CFG_POS, $urandom());
      write_reg(tmp_pkg::CFG_TSTEP, $urandom());
      write_reg(tmp_pkg::CFG_PSCALE, $urandom());
    end else begin
      write_reg(tmp_pkg::CFG_ACCEL, $urandom_range(32'h40_0000, 32'h400));
      write_reg(tmp_pkg::CFG_VEL, $urandom_range(32'h10_0000, 32'h1000));
      write_reg(tmp_pkg::CFG_POS, $urandom_range(32'h40_0000, 0));
      write_reg(tmp_pkg::CFG_TSTEP,
                $urandom_range(32'h1_0000, 32'h800) | ($urandom() & 32'hFFFE_0000));
      write_reg(tmp_pkg::CFG_PSCALE,
                $urandom_range(32'h4_0000, 1) | ($urandom() & 32'h8000_0000));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_taken = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tmp_pkg::CFG_ACCEL;
    cfg_data = 32'd0;
    failed = 1'b0;
    hold_reqs = 0; hold_seen = 0; hold_cnt = 0;
    quiet_cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    m_accel = 31'd65536; m_vel = 31'd65536; m_pos = 31'd65536;
    m_tstep = 17'd655; m_scale = 31'd65536;
    m_time = 0; m_half_acc = 0; m_cruise_off = 0; m_dec_sq = 0; m_dec_lin = 0;
    m_dec_const = 0; m_end_acc = 0; m_end_cruise = 0; m_end_move = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ticks before any restart, then a default move
    tick_queue.push_back(8'h00);
    tick_queue.push_back(8'h00);
    tick_queue.push_back(8'h01);
    tick_queue.push_back(8'h00);
    drain();
    // short move with a vel_max change during cruise
    write_reg(tmp_pkg::CFG_TSTEP, 32'h1_0000);
    write_reg(tmp_pkg::CFG_ACCEL, 32'h4_0000);
    write_reg(tmp_pkg::CFG_VEL, 32'h1_0000);
    write_reg(tmp_pkg::CFG_POS, 32'h5_0000);
    tick_queue.push_back(8'h01);
    tick_queue.push_back(8'h00);
    tick_queue.push_back(8'h00);
    drain();
    write_reg(tmp_pkg::CFG_VEL, 32'h2_8000);
    add_ticks(6, 1000);
    tick_queue[0] = 8'h00;
    drain();
    // zero divisors, zero time step, register extremes
    write_reg(tmp_pkg::CFG_ACCEL, 32'h0);
    write_reg(tmp_pkg::CFG_TSTEP, 32'h0);
    add_ticks(2, 1000);
    drain();
    write_reg(tmp_pkg::CFG_VEL, 32'h8000_0000);
    write_reg(tmp_pkg::CFG_TSTEP, 32'hFFFF_FFFF);
    write_reg(tmp_pkg::CFG_PSCALE, 32'hFFFF_FFFF);
    add_ticks(2, 1000);
    drain();
    write_reg(tmp_pkg::CFG_ACCEL, 32'h7FFF_FFFF);
    write_reg(tmp_pkg::CFG_VEL, 32'h7FFF_FFFF);
    write_reg(tmp_pkg::CFG_POS, 32'h7FFF_FFFF);
    add_ticks(3, 1000);
    drain();
    write_reg(tmp_pkg::CFG_ACCEL, 32'h1);
    write_reg(tmp_pkg::CFG_VEL, 32'h1);
    write_reg(tmp_pkg::CFG_POS, 32'h0);
    write_reg(tmp_pkg::CFG_PSCALE, 32'h1);
    add_ticks(3, 1000);
    drain();

    // random moves under three idle patterns
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 70 : 0;
      recv_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 7 : 0;
      for (int ph = 0; ph < 11; ph++) begin
        random_setup();
        if (ph == 3) hold_reqs = hold_reqs + 1;
        add_ticks(50, 40);
        drain();
      end
    end

    if (!failed) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
